// ===== design/sapm_pkg.sv =====
`default_nettype none

package sapm_pkg;

    localparam int PERIOD_COUNT_DEF = 13019;
    localparam int PERIOD_US_DEF    = 20000;

    localparam int FRAC_BITS = 17;
    localparam int MUL_BITS  = 17;
    localparam int LDIV_BITS = 32;

    localparam logic [16:0] FRAC_ONE = 17'h10000;

    localparam logic signed [17:0] HARD_MIN_Q4 = 18'sd4800;
    localparam logic signed [17:0] HARD_MAX_Q4 = 18'sd43200;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_ANGLE   = 2'd0;
    localparam opcode_t OP_PULSE   = 2'd1;
    localparam opcode_t OP_REAPPLY = 2'd2;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SAFE_MIN = 3'd0;
    localparam cfg_idx_t CFG_SAFE_MAX = 3'd1;
    localparam cfg_idx_t CFG_CAL_MIN  = 3'd2;
    localparam cfg_idx_t CFG_CAL_MAX  = 3'd3;
    localparam cfg_idx_t CFG_PLS_MIN  = 3'd4;
    localparam cfg_idx_t CFG_PLS_MAX  = 3'd5;
    localparam cfg_idx_t CFG_TRIM     = 3'd6;
    localparam cfg_idx_t CFG_DIR      = 3'd7;

    localparam logic [14:0]        SAFE_MIN_RST   = 15'd1000;
    localparam logic [14:0]        SAFE_MAX_RST   = 15'd3000;
    localparam logic [14:0]        CAL_MIN_RST    = 15'd0;
    localparam logic [14:0]        CAL_MAX_RST    = 15'd17000;
    localparam logic [15:0]        PLS_MIN_RST    = 16'd8800;
    localparam logic [15:0]        PLS_MAX_RST    = 16'd40000;
    localparam logic signed [15:0] TRIM_RST       = 16'sd0;
    localparam logic               DIR_RST        = 1'b0;
    localparam logic [14:0]        LAST_ANGLE_RST = 15'd1000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_TRIM,
        ST_NORM,
        ST_DIV,
        ST_FRAC,
        ST_MUL,
        ST_POST,
        ST_BACK,
        ST_LMUL,
        ST_LDIV,
        ST_DONE
    } state_t;

    function automatic logic signed [17:0] clamp18(
        input logic signed [17:0] v,
        input logic signed [17:0] lo,
        input logic signed [17:0] hi
    );
        logic signed [17:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/servo_angle_pulse_mapper_top.sv =====
// Beats are taken one at a time: s_tready is high only while the sequencer is idle,
// and it goes back to idle once the result is loaded into the output register.
// One bit-serial datapath runs a 17-step normalize divide, a 17-step span multiply,
// a 17-step level multiply and a 32-step level divide in turn.
// Reset (rst_n low, asynchronous): registers to their defaults, last angle 1000 cdeg,
// sequencer idle, no output beat pending.
`default_nettype none

module servo_angle_pulse_mapper_top #(
    parameter int PERIOD_COUNT = sapm_pkg::PERIOD_COUNT_DEF,
    parameter int PERIOD_US    = sapm_pkg::PERIOD_US_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_idx,
    input  wire  [15:0] cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // angle_cdeg [16:0], pulse_q4 [32:17], zero [39:33]
    input  wire  [1:0]  s_tuser,   // opcode [1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata    // pwm_level [15:0], last_angle_cdeg [30:16], zero [31]
);

    localparam int LVL_DEN = PERIOD_US * 16;
    localparam int DEN_W   = $clog2(LVL_DEN + 1);
    localparam int CNT_W   = $clog2(sapm_pkg::LDIV_BITS);

    localparam logic [15:0]      PC_Q      = 16'(PERIOD_COUNT);
    localparam logic [DEN_W:0]   LVL_DEN_Q = (DEN_W + 1)'(LVL_DEN);
    localparam logic [CNT_W-1:0] DIV_LOAD  = CNT_W'(sapm_pkg::FRAC_BITS - 1);
    localparam logic [CNT_W-1:0] MUL_LOAD  = CNT_W'(sapm_pkg::MUL_BITS - 1);
    localparam logic [CNT_W-1:0] LDIV_LOAD = CNT_W'(sapm_pkg::LDIV_BITS - 1);

    logic [14:0]        safe_min_reg;
    logic [14:0]        safe_max_reg;
    logic [14:0]        cal_min_reg;
    logic [14:0]        cal_max_reg;
    logic [15:0]        pulse_min_reg;
    logic [15:0]        pulse_max_reg;
    logic signed [15:0] trim_reg;
    logic               dir_pos_reg;
    logic [14:0]        last_angle_reg;

    sapm_pkg::state_t   state_reg;
    sapm_pkg::state_t   state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               m_tvalid_reg;
    logic               load_out;

    logic               pulse_mode_reg;
    logic signed [16:0] ang_src_reg;
    logic [15:0]        pulse_in_reg;
    logic [14:0]        base_reg;
    logic [14:0]        sa_reg;
    logic [15:0]        p_reg;
    logic [15:0]        num_reg;
    logic [15:0]        den_reg;
    logic               frac_zero_reg;
    logic [16:0]        q_reg;
    logic [16:0]        hi_reg;
    logic [16:0]        lo_reg;
    logic [15:0]        mcand_reg;
    logic [DEN_W-1:0]   lrem_reg;
    logic [31:0]        ldq_reg;
    logic [15:0]        pwm_reg;
    logic [14:0]        out_angle_reg;

    logic signed [17:0] smin_s;
    logic signed [17:0] smax_s;
    logic signed [17:0] cmin_s;
    logic signed [17:0] cmax_s;
    logic signed [17:0] pmin_s;
    logic signed [17:0] pmax_s;
    logic signed [17:0] trim_ext;
    logic signed [15:0] cspan;
    logic signed [16:0] pspan;
    logic [15:0]        cspan_mag;

    logic signed [17:0] base_w;
    logic signed [17:0] hard_w;
    logic signed [17:0] sa_trim_w;
    logic signed [17:0] cal_c_w;
    logic signed [17:0] pls_c_w;
    logic signed [17:0] back_ang_w;
    logic signed [17:0] sa_back_w;
    logic signed [17:0] base_back_w;
    logic [15:0]        mprod_w;
    logic [15:0]        pulse_ang_w;

    logic [16:0]        dtrial;
    logic               dge;
    logic [16:0]        frac_raw;
    logic [16:0]        frac_w;
    logic [17:0]        msum;
    logic [DEN_W:0]     ltrial;
    logic               lge;
    logic [15:0]        level_w;

    assign smin_s   = $signed({3'b000, safe_min_reg});
    assign smax_s   = $signed({3'b000, safe_max_reg});
    assign cmin_s   = $signed({3'b000, cal_min_reg});
    assign cmax_s   = $signed({3'b000, cal_max_reg});
    assign pmin_s   = $signed({2'b00, pulse_min_reg});
    assign pmax_s   = $signed({2'b00, pulse_max_reg});
    assign trim_ext = $signed({{2{trim_reg[15]}}, trim_reg});

    assign cspan     = $signed({1'b0, cal_max_reg}) - $signed({1'b0, cal_min_reg});
    assign pspan     = $signed({1'b0, pulse_max_reg}) - $signed({1'b0, pulse_min_reg});
    assign cspan_mag = cspan[15] ? 16'(-cspan) : cspan;

    assign base_w    = sapm_pkg::clamp18({ang_src_reg[16], ang_src_reg}, smin_s, smax_s);
    assign hard_w    = sapm_pkg::clamp18($signed({2'b00, pulse_in_reg}),
                                         sapm_pkg::HARD_MIN_Q4, sapm_pkg::HARD_MAX_Q4);
    assign sa_trim_w = sapm_pkg::clamp18($signed({3'b000, base_reg}) + trim_ext,
                                         smin_s, smax_s);
    assign cal_c_w   = sapm_pkg::clamp18($signed({3'b000, sa_reg}), cmin_s, cmax_s);
    assign pls_c_w   = sapm_pkg::clamp18($signed({2'b00, p_reg}), pmin_s, pmax_s);

    assign mprod_w     = {hi_reg[14:0], lo_reg[16]};
    assign pulse_ang_w = (pspan > 17'sd0) ? pulse_min_reg + mprod_w : pulse_min_reg;
    assign back_ang_w  = cspan[15] ? cmin_s - $signed({2'b00, mprod_w})
                                   : cmin_s + $signed({2'b00, mprod_w});
    assign sa_back_w   = sapm_pkg::clamp18(back_ang_w, smin_s, smax_s);
    assign base_back_w = sapm_pkg::clamp18($signed({3'b000, sa_reg}) - trim_ext,
                                           smin_s, smax_s);

    assign dtrial = (cnt_reg == DIV_LOAD) ? {1'b0, num_reg} : {num_reg, 1'b0};
    assign dge    = dtrial >= {1'b0, den_reg};

    assign frac_raw = frac_zero_reg ? 17'd0 : q_reg;
    assign frac_w   = dir_pos_reg ? frac_raw : sapm_pkg::FRAC_ONE - frac_raw;

    assign msum = {1'b0, hi_reg} + (lo_reg[0] ? {2'b00, mcand_reg} : 18'd0);

    assign ltrial = {lrem_reg, ldq_reg[31]};
    assign lge    = ltrial >= LVL_DEN_Q;

    assign level_w = (|ldq_reg[31:16]) ? 16'hFFFF : ldq_reg[15:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sapm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sapm_pkg::ST_BASE;
                end
            end
            sapm_pkg::ST_BASE:
            begin
                state_next = pulse_mode_reg ? sapm_pkg::ST_NORM : sapm_pkg::ST_TRIM;
            end
            sapm_pkg::ST_TRIM: state_next = sapm_pkg::ST_NORM;
            sapm_pkg::ST_NORM: state_next = sapm_pkg::ST_DIV;
            sapm_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sapm_pkg::ST_FRAC;
                end
            end
            sapm_pkg::ST_FRAC: state_next = sapm_pkg::ST_MUL;
            sapm_pkg::ST_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sapm_pkg::ST_POST;
                end
            end
            sapm_pkg::ST_POST:
            begin
                state_next = pulse_mode_reg ? sapm_pkg::ST_BACK : sapm_pkg::ST_LMUL;
            end
            sapm_pkg::ST_BACK: state_next = sapm_pkg::ST_LMUL;
            sapm_pkg::ST_LMUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sapm_pkg::ST_LDIV;
                end
            end
            sapm_pkg::ST_LDIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sapm_pkg::ST_DONE;
                end
            end
            sapm_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = sapm_pkg::ST_IDLE;
                end
            end
            default: state_next = sapm_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            sapm_pkg::ST_IDLE: s_tready = 1'b1;
            sapm_pkg::ST_DONE: load_out = !m_tvalid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_angle_reg, pwm_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_min_reg   <= sapm_pkg::SAFE_MIN_RST;
            safe_max_reg   <= sapm_pkg::SAFE_MAX_RST;
            cal_min_reg    <= sapm_pkg::CAL_MIN_RST;
            cal_max_reg    <= sapm_pkg::CAL_MAX_RST;
            pulse_min_reg  <= sapm_pkg::PLS_MIN_RST;
            pulse_max_reg  <= sapm_pkg::PLS_MAX_RST;
            trim_reg       <= sapm_pkg::TRIM_RST;
            dir_pos_reg    <= sapm_pkg::DIR_RST;
            last_angle_reg <= sapm_pkg::LAST_ANGLE_RST;
            state_reg      <= sapm_pkg::ST_IDLE;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    sapm_pkg::CFG_SAFE_MIN: safe_min_reg  <= cfg_wdata[14:0];
                    sapm_pkg::CFG_SAFE_MAX: safe_max_reg  <= cfg_wdata[14:0];
                    sapm_pkg::CFG_CAL_MIN:  cal_min_reg   <= cfg_wdata[14:0];
                    sapm_pkg::CFG_CAL_MAX:  cal_max_reg   <= cfg_wdata[14:0];
                    sapm_pkg::CFG_PLS_MIN:  pulse_min_reg <= cfg_wdata;
                    sapm_pkg::CFG_PLS_MAX:  pulse_max_reg <= cfg_wdata;
                    sapm_pkg::CFG_TRIM:     trim_reg      <= $signed(cfg_wdata);
                    sapm_pkg::CFG_DIR:      dir_pos_reg   <= cfg_wdata[0];
                    default:                dir_pos_reg   <= dir_pos_reg;
                endcase
            end
            case (state_reg)
                sapm_pkg::ST_NORM: cnt_reg <= DIV_LOAD;
                sapm_pkg::ST_FRAC: cnt_reg <= MUL_LOAD;
                sapm_pkg::ST_POST:
                begin
                    if (!pulse_mode_reg)
                    begin
                        cnt_reg <= MUL_LOAD;
                    end
                end
                sapm_pkg::ST_BACK: cnt_reg <= MUL_LOAD;
                sapm_pkg::ST_LMUL:
                begin
                    cnt_reg <= (cnt_reg == '0) ? LDIV_LOAD : cnt_reg - 1'b1;
                end
                sapm_pkg::ST_DIV, sapm_pkg::ST_MUL, sapm_pkg::ST_LDIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                default: cnt_reg <= cnt_reg;
            endcase
            if (load_out)
            begin
                last_angle_reg <= base_reg;
                m_tvalid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sapm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pulse_mode_reg <= (s_tuser == sapm_pkg::OP_PULSE);
                    ang_src_reg    <= (s_tuser == sapm_pkg::OP_ANGLE)
                                      ? $signed(s_tdata[16:0])
                                      : $signed({2'b00, last_angle_reg});
                    pulse_in_reg   <= s_tdata[32:17];
                end
            end
            sapm_pkg::ST_BASE:
            begin
                base_reg <= base_w[14:0];
                p_reg    <= hard_w[15:0];
            end
            sapm_pkg::ST_TRIM:
            begin
                sa_reg <= sa_trim_w[14:0];
            end
            sapm_pkg::ST_NORM:
            begin
                if (pulse_mode_reg)
                begin
                    num_reg       <= pls_c_w[15:0] - pulse_min_reg;
                    den_reg       <= pspan[15:0];
                    frac_zero_reg <= (pspan <= 17'sd0);
                end
                else
                begin
                    num_reg       <= cal_c_w[15:0] - {1'b0, cal_min_reg};
                    den_reg       <= cspan;
                    frac_zero_reg <= (cspan <= 16'sd0);
                end
            end
            sapm_pkg::ST_DIV:
            begin
                num_reg <= dge ? 16'(dtrial - {1'b0, den_reg}) : dtrial[15:0];
                q_reg   <= {q_reg[15:0], dge};
            end
            sapm_pkg::ST_FRAC:
            begin
                hi_reg    <= '0;
                lo_reg    <= frac_w;
                mcand_reg <= pulse_mode_reg ? cspan_mag : pspan[15:0];
            end
            sapm_pkg::ST_MUL:
            begin
                hi_reg <= msum[17:1];
                lo_reg <= {msum[0], lo_reg[16:1]};
            end
            sapm_pkg::ST_POST:
            begin
                if (pulse_mode_reg)
                begin
                    sa_reg <= sa_back_w[14:0];
                end
                else
                begin
                    hi_reg    <= '0;
                    lo_reg    <= {1'b0, pulse_ang_w};
                    mcand_reg <= PC_Q;
                end
            end
            sapm_pkg::ST_BACK:
            begin
                base_reg  <= base_back_w[14:0];
                hi_reg    <= '0;
                lo_reg    <= {1'b0, p_reg};
                mcand_reg <= PC_Q;
            end
            sapm_pkg::ST_LMUL:
            begin
                hi_reg <= msum[17:1];
                lo_reg <= {msum[0], lo_reg[16:1]};
                if (cnt_reg == '0)
                begin
                    ldq_reg  <= {msum[15:0], lo_reg[16:1]};
                    lrem_reg <= '0;
                end
            end
            sapm_pkg::ST_LDIV:
            begin
                lrem_reg <= lge ? DEN_W'(ltrial - LVL_DEN_Q) : ltrial[DEN_W-1:0];
                ldq_reg  <= {ldq_reg[30:0], lge};
            end
            sapm_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    pwm_reg       <= level_w;
                    out_angle_reg <= base_reg;
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == sapm_pkg::ST_BASE))
        else $error("accepted beat did not start the sequence");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sapm_pkg::ST_DIV) |-> (cnt_reg <= DIV_LOAD))
        else $error("normalize divide step count out of range");

    a_span_product: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sapm_pkg::ST_POST) |-> (hi_reg[16:15] == 2'b00))
        else $error("span product exceeds 32 bits");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == sapm_pkg::ST_DONE))
        else $error("output beat raised outside the final step");

    a_last_angle_match: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (m_tdata[30:16] == last_angle_reg))
        else $error("output angle differs from stored last angle");

endmodule

`default_nettype wire

// ===== tb/servo_mapper_checker.sv =====
`timescale 1ns / 100ps

module servo_mapper_checker #(
    parameter int PERIOD_COUNT = sapm_pkg::PERIOD_COUNT_DEF,
    parameter int PERIOD_US    = sapm_pkg::PERIOD_US_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_idx,
    input  wire  [15:0] cfg_wdata,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [39:0] s_tdata,   // angle_cdeg [16:0], pulse_q4 [32:17], zero [39:33]
    input  wire  [1:0]  s_tuser,   // opcode [1:0]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,   // pwm_level [15:0], last_angle_cdeg [30:16], zero [31]
    output int          mismatches,
    output int          pending,
    output int          results
);

    localparam longint FRAC_UNIT      = 65536;
    localparam longint PULSE_FLOOR_Q4 = 4800;
    localparam longint PULSE_CEIL_Q4  = 43200;

    typedef struct packed {
        logic [15:0] pwm;
        logic [14:0] angle;
    } pwm_angle_t;

    longint       safe_lo;
    longint       safe_hi;
    longint       cal_lo;
    longint       cal_hi;
    longint       pls_lo;
    longint       pls_hi;
    longint       trim;
    logic         dir_keep;
    logic [14:0]  held_angle;
    pwm_angle_t   pwm_angle_due[$];
    int           fail_tally;
    int           result_tally;

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [15:0] pwm_of(input longint pulse);
        longint p;
        longint q;
        p = (pulse < 0) ? 0 : pulse;
        q = (p * longint'(PERIOD_COUNT)) / (longint'(PERIOD_US) * 16);
        if (q > 65535)
        begin
            q = 65535;
        end
        return q[15:0];
    endfunction

    function automatic longint angle_to_pulse_q4(input longint sa);
        longint c;
        longint span;
        longint frac;
        longint pspan;
        c = clamp_range(sa, cal_lo, cal_hi);
        span = cal_hi - cal_lo;
        frac = 0;
        if (span > 0)
        begin
            frac = ((c - cal_lo) * FRAC_UNIT) / span;
        end
        frac = clamp_range(frac, 0, FRAC_UNIT);
        if (!dir_keep)
        begin
            frac = FRAC_UNIT - frac;
        end
        pspan = pls_hi - pls_lo;
        if (pspan <= 0)
        begin
            return pls_lo;
        end
        return pls_lo + (frac * pspan) / FRAC_UNIT;
    endfunction

    function automatic longint pulse_to_angle_cdeg(input longint pulse);
        longint c;
        longint pspan;
        longint frac;
        longint dspan;
        longint ang;
        c = clamp_range(pulse, pls_lo, pls_hi);
        pspan = pls_hi - pls_lo;
        frac = 0;
        if (pspan > 0)
        begin
            frac = ((c - pls_lo) * FRAC_UNIT) / pspan;
        end
        frac = clamp_range(frac, 0, FRAC_UNIT);
        if (!dir_keep)
        begin
            frac = FRAC_UNIT - frac;
        end
        dspan = cal_hi - cal_lo;
        ang = cal_lo + (frac * dspan) / FRAC_UNIT;
        return clamp_range(ang, safe_lo, safe_hi);
    endfunction

    function automatic pwm_angle_t map_command(
        input sapm_pkg::opcode_t  op,
        input logic signed [16:0] angle_in,
        input logic [15:0]        pulse_in
    );
        longint     p;
        longint     a;
        longint     sa;
        longint     base;
        pwm_angle_t r;
        if (op == sapm_pkg::OP_PULSE)
        begin
            p = clamp_range(longint'(pulse_in), PULSE_FLOOR_Q4, PULSE_CEIL_Q4);
            r.pwm = pwm_of(p);
            sa = pulse_to_angle_cdeg(clamp_range(p, pls_lo, pls_hi));
            base = clamp_range(sa - trim, safe_lo, safe_hi);
        end
        else
        begin
            if (op == sapm_pkg::OP_ANGLE)
            begin
                a = longint'(angle_in);
            end
            else
            begin
                a = longint'(held_angle);
            end
            base = clamp_range(a, safe_lo, safe_hi);
            sa = clamp_range(base + trim, safe_lo, safe_hi);
            r.pwm = pwm_of(angle_to_pulse_q4(sa));
        end
        held_angle = base[14:0];
        r.angle = held_angle;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pwm_angle_t want;
        if (!rst_n)
        begin
            safe_lo = longint'(sapm_pkg::SAFE_MIN_RST);
            safe_hi = longint'(sapm_pkg::SAFE_MAX_RST);
            cal_lo = longint'(sapm_pkg::CAL_MIN_RST);
            cal_hi = longint'(sapm_pkg::CAL_MAX_RST);
            pls_lo = longint'(sapm_pkg::PLS_MIN_RST);
            pls_hi = longint'(sapm_pkg::PLS_MAX_RST);
            trim = longint'(sapm_pkg::TRIM_RST);
            dir_keep = sapm_pkg::DIR_RST;
            held_angle = sapm_pkg::LAST_ANGLE_RST;
            pwm_angle_due.delete();
            fail_tally = 0;
            result_tally = 0;
            mismatches <= 0;
            pending <= 0;
            results <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    sapm_pkg::CFG_SAFE_MIN: safe_lo = longint'(cfg_wdata[14:0]);
                    sapm_pkg::CFG_SAFE_MAX: safe_hi = longint'(cfg_wdata[14:0]);
                    sapm_pkg::CFG_CAL_MIN:  cal_lo = longint'(cfg_wdata[14:0]);
                    sapm_pkg::CFG_CAL_MAX:  cal_hi = longint'(cfg_wdata[14:0]);
                    sapm_pkg::CFG_PLS_MIN:  pls_lo = longint'(cfg_wdata);
                    sapm_pkg::CFG_PLS_MAX:  pls_hi = longint'(cfg_wdata);
                    sapm_pkg::CFG_TRIM:     trim = longint'($signed(cfg_wdata));
                    sapm_pkg::CFG_DIR:      dir_keep = cfg_wdata[0];
                    default:                ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                pwm_angle_due.push_back(map_command(s_tuser, $signed(s_tdata[16:0]),
                                                    s_tdata[32:17]));
            end
            if (m_tvalid && m_tready)
            begin
                result_tally++;
                if (pwm_angle_due.size() == 0)
                begin
                    if (fail_tally < 10)
                    begin
                        $display("beat with nothing due: pwm %0d angle %0d",
                                 m_tdata[15:0], m_tdata[30:16]);
                    end
                    fail_tally++;
                end
                else
                begin
                    want = pwm_angle_due.pop_front();
                    if (m_tdata[15:0] !== want.pwm || m_tdata[30:16] !== want.angle)
                    begin
                        if (fail_tally < 10)
                        begin
                            $display({"mismatch at beat %0d: pwm exp %0d got %0d, ",
                                      "angle exp %0d got %0d"},
                                     result_tally, want.pwm, m_tdata[15:0],
                                     want.angle, m_tdata[30:16]);
                        end
                        fail_tally++;
                    end
                end
            end
            pending <= pwm_angle_due.size();
            mismatches <= fail_tally;
            results <= result_tally;
        end
    end

endmodule

// ===== tb/servo_angle_pulse_mapper_top_tb.sv =====
`timescale 1ns / 100ps

module servo_angle_pulse_mapper_top_tb;

    localparam sapm_pkg::opcode_t OP_SPARE       = 2'd3;
    localparam int                WATCHDOG_LIMIT = 4000;

    typedef struct {
        int safe_min;
        int safe_max;
        int cal_min;
        int cal_max;
        int pls_min;
        int pls_max;
        int trim;
        int dir;
    } mapper_regs_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = 3'd0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = 40'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int mismatches;
    int pending;
    int results;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_cycles = 0;
    int commands_sent = 0;
    int settings_used = 0;

    servo_angle_pulse_mapper_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    servo_mapper_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending),
        .results    (results)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_command(input sapm_pkg::opcode_t op, input int ang, input int pls);
        logic [31:0] a;
        logic [31:0] p;
        a = ang;
        p = pls;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, p[15:0], a[16:0]};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        commands_sent++;
    endtask

    // drop valid and hold until every predicted beat has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input sapm_pkg::cfg_idx_t idx, input int val);
        logic [31:0] v;
        v = val;
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= v[15:0];
        @(posedge clk);
    endtask

    task automatic apply_regs(input mapper_regs_t r);
        write_reg(sapm_pkg::CFG_SAFE_MIN, r.safe_min);
        write_reg(sapm_pkg::CFG_SAFE_MAX, r.safe_max);
        write_reg(sapm_pkg::CFG_CAL_MIN, r.cal_min);
        write_reg(sapm_pkg::CFG_CAL_MAX, r.cal_max);
        write_reg(sapm_pkg::CFG_PLS_MIN, r.pls_min);
        write_reg(sapm_pkg::CFG_PLS_MAX, r.pls_max);
        write_reg(sapm_pkg::CFG_TRIM, r.trim);
        write_reg(sapm_pkg::CFG_DIR, r.dir);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic int pick_limit(input int top);
        int r;
        r = $urandom_range(7);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 1)
        begin
            return top;
        end
        return $urandom_range(top);
    endfunction

    function automatic mapper_regs_t rand_regs;
        mapper_regs_t r;
        int           t;
        r.safe_min = pick_limit(18000);
        r.safe_max = pick_limit(18000);
        r.cal_min = pick_limit(18000);
        r.cal_max = pick_limit(18000);
        r.pls_min = pick_limit(65535);
        r.pls_max = pick_limit(65535);
        // keep most ranges ordered so the linear maps are exercised
        if ($urandom_range(4) != 0 && r.safe_min > r.safe_max)
        begin
            t = r.safe_min;
            r.safe_min = r.safe_max;
            r.safe_max = t;
        end
        if ($urandom_range(4) != 0 && r.cal_min > r.cal_max)
        begin
            t = r.cal_min;
            r.cal_min = r.cal_max;
            r.cal_max = t;
        end
        if ($urandom_range(4) != 0 && r.pls_min > r.pls_max)
        begin
            t = r.pls_min;
            r.pls_min = r.pls_max;
            r.pls_max = t;
        end
        case ($urandom_range(3))
            0:       r.trim = ($urandom_range(1) == 0) ? -18000 : 18000;
            1:       r.trim = int'($urandom_range(36000)) - 18000;
            default: r.trim = int'($urandom_range(4000)) - 2000;
        endcase
        r.dir = $urandom_range(1);
        return r;
    endfunction

    task automatic send_random;
        sapm_pkg::opcode_t op;
        int                ang;
        int                pls;
        int                r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            op = sapm_pkg::OP_ANGLE;
        end
        else if (r < 70)
        begin
            op = sapm_pkg::OP_PULSE;
        end
        else if (r < 90)
        begin
            op = sapm_pkg::OP_REAPPLY;
        end
        else
        begin
            op = OP_SPARE;
        end
        r = $urandom_range(9);
        if (r < 5)
        begin
            ang = $urandom_range(18000);
        end
        else if (r < 8)
        begin
            ang = int'($urandom_range(72000)) - 36000;
        end
        else
        begin
            ang = $urandom();
        end
        if ($urandom_range(1) == 0)
        begin
            pls = $urandom_range(44000, 4000);
        end
        else
        begin
            pls = $urandom();
        end
        send_command(op, ang, pls);
    endtask

    initial
    begin
        mapper_regs_t r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 24;
        stall_pct = 64;

        send_command(sapm_pkg::OP_ANGLE, -36000, 0);
        send_command(sapm_pkg::OP_ANGLE, 36000, 65535);
        send_command(sapm_pkg::OP_ANGLE, -65536, 0);
        send_command(sapm_pkg::OP_ANGLE, 2000, 0);
        send_command(sapm_pkg::OP_PULSE, 0, 0);
        send_command(sapm_pkg::OP_PULSE, 0, 65535);
        send_command(sapm_pkg::OP_PULSE, 0, 4800);
        send_command(sapm_pkg::OP_PULSE, 0, 43200);
        send_command(sapm_pkg::OP_REAPPLY, 0, 0);
        send_command(OP_SPARE, 0, 0);

        drain();
        r = '{0, 18000, 0, 18000, 0, 65535, 18000, 1};
        apply_regs(r);
        send_command(sapm_pkg::OP_ANGLE, 18000, 0);
        send_command(sapm_pkg::OP_ANGLE, 0, 0);
        send_command(sapm_pkg::OP_PULSE, 0, 30000);
        send_command(sapm_pkg::OP_REAPPLY, 0, 0);

        // crossed bounds everywhere
        drain();
        r = '{18000, 0, 18000, 0, 65535, 0, -18000, 0};
        apply_regs(r);
        send_command(sapm_pkg::OP_ANGLE, 9000, 0);
        send_command(sapm_pkg::OP_PULSE, 0, 20000);
        send_command(sapm_pkg::OP_REAPPLY, 0, 0);

        // empty calibration and pulse spans
        drain();
        r = '{0, 18000, 9000, 9000, 20000, 20000, 0, 1};
        apply_regs(r);
        send_command(sapm_pkg::OP_ANGLE, 5000, 0);
        send_command(sapm_pkg::OP_PULSE, 0, 30000);

        // negative calibration span mapped back from a pulse and forward from an angle
        drain();
        r = '{0, 18000, 15000, 3000, 8000, 40000, 0, 1};
        apply_regs(r);
        send_command(sapm_pkg::OP_PULSE, 0, 25000);
        send_command(sapm_pkg::OP_PULSE, 0, 43200);
        send_command(sapm_pkg::OP_ANGLE, 6000, 0);

        for (int seg = 0; seg < 16; seg++)
        begin
            if (seg < 5)
            begin
                gap_pct = 24;
                stall_pct = 64;
            end
            else if (seg < 10)
            begin
                gap_pct = 64;
                stall_pct = 24;
            end
            else
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            drain();
            if (seg == 3)
            begin
                r = '{0, 18000, 0, 18000, 0, 65535, -18000, 0};
            end
            else if (seg == 7)
            begin
                r = '{18000, 18000, 18000, 0, 65535, 65535, 18000, 1};
            end
            else
            begin
                r = rand_regs();
            end
            apply_regs(r);
            for (int n = 0; n < 50; n++)
            begin
                if (n == 25 || $urandom_range(199) == 0)
                begin
                    drain();
                end
                send_random();
            end
        end

        drain();
        repeat (120) @(posedge clk);
        $display("ran %0d commands under %0d register settings, %0d result beats checked",
                 commands_sent, settings_used + 1, results);
        $display("pacing: sender gaps and receiver stalls swapped, then full rate");
        if (mismatches == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
